### rtl/pmbr_pkg.sv
// Shared constants, types and helper functions of the cursor shape renderer.
package pmbr_pkg;

  localparam int MAX_DIM    = 384;
  localparam int DEPTH_W    = 6;
  localparam int DIM_W      = 9;
  localparam int IDX_W      = 18;
  localparam int CH_W       = 8;
  localparam int XOR_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [DEPTH_W-1:0] DEPTH_1  = 6'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_4  = 6'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_8  = 6'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_15 = 6'd15;
  localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_24 = 6'd24;
  localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd32;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_32;

  localparam logic [CH_W-1:0] CH_FULL = 8'hFF;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PALETTE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FMT_MONO  = 2'd0,
    FMT_555   = 2'd1,
    FMT_RGB24 = 2'd2,
    FMT_RGB32 = 2'd3
  } fmt_t;

  // one pixel between the index stage and the colour stage
  typedef struct packed {
    logic             and_bit;
    logic [XOR_W-1:0] xor_pixel;
    fmt_t             fmt;
    logic             odd;
    logic [IDX_W-1:0] pixel_index;
    logic             last_pixel;
    status_t          status;
  } s1_t;

  function automatic logic [CH_W-1:0] ext5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) res = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    else res = d;
    return res;
  endfunction

endpackage

### rtl/pmbr_in_if.sv
// Pixel input channel: AND bit and raw XOR value.
interface pmbr_in_if import pmbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             and_bit;
  logic [XOR_W-1:0] xor_pixel;

  modport source (output valid, output and_bit, output xor_pixel, input ready);
  modport sink   (input valid, input and_bit, input xor_pixel, output ready);
endinterface

### rtl/pmbr_out_if.sv
// Result channel: BGRA pixel with output position, last flag and status.
interface pmbr_out_if import pmbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  blue;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  alpha;
  logic [IDX_W-1:0] pixel_index;
  logic             last_pixel;
  logic [1:0]       status;

  modport source (output valid, output blue, output green, output red, output alpha,
                  output pixel_index, output last_pixel, output status, input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha,
                  input pixel_index, input last_pixel, input status, output ready);
endinterface

### rtl/pmbr_cfg_if.sv
// Configuration write channel: register index and write data.
interface pmbr_cfg_if import pmbr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pointer_mask_to_bgra_renderer_top.sv
// Pipeline: two register stages; a result beat is offered once its input beat has passed both registers.
// Throughput: one pixel per cycle while the output is not stalled; the first stage holds the 9x9 row-base
// multiply, the second the colour decode, each closed by a register.
// Reset: depth 32 bpp, 32x32 shape, scan counters at zero, pipeline empty.
// A write to the depth, width or height register restarts the shape at its first pixel.
module pointer_mask_to_bgra_renderer_top import pmbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pmbr_cfg_if.sink  cfg_ch,
  pmbr_in_if.sink   in_ch,
  pmbr_out_if.source out_ch
);

  logic [DEPTH_W-1:0] depth_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [DIM_W-1:0]   column_count_r, column_count_nxt;
  logic [DIM_W-1:0]   line_count_r, line_count_nxt;

  logic               s1_valid_r;
  s1_t                s1_r, s1_nxt;

  logic               out_valid_r;
  logic [CH_W-1:0]    blue_r, green_r, red_r, alpha_r;
  logic [CH_W-1:0]    blue_nxt, green_nxt, red_nxt, alpha_nxt;
  logic [IDX_W-1:0]   pixel_index_r;
  logic               last_pixel_r;
  status_t            status_r;

  logic               in_acc, cfg_acc, cfg_hit, s1_adv;
  logic [DIM_W-1:0]   wd, hd, col, line, y;
  logic [IDX_W-1:0]   row_base;
  logic               col_end, line_end, dims_ok;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    case (cfg_ch.index)
      REG_DEPTH, REG_WIDTH, REG_HEIGHT: cfg_hit = 1'b1;
      default:                          cfg_hit = 1'b0;
    endcase
  end

  // ---------------- index stage ----------------
  always_comb begin
    wd   = clamp_dim(width_r);
    hd   = clamp_dim(height_r);
    col  = (column_count_r < wd) ? column_count_r : '0;
    line = (line_count_r < hd) ? line_count_r : '0;
    // stored lines run bottom-up except at 1 bpp
    y    = (depth_r == DEPTH_1) ? line : (hd - DIM_W'(1) - line);
    row_base = IDX_W'(y) * IDX_W'(wd);
    col_end  = (col == wd - DIM_W'(1));
    line_end = (line == hd - DIM_W'(1));
    dims_ok  = (width_r != '0) && (width_r <= DIM_W'(MAX_DIM)) &&
               (height_r != '0) && (height_r <= DIM_W'(MAX_DIM));

    s1_nxt.and_bit     = in_ch.and_bit;
    s1_nxt.xor_pixel   = in_ch.xor_pixel;
    s1_nxt.odd         = col[0] ^ y[0];
    s1_nxt.pixel_index = row_base + IDX_W'(col);
    s1_nxt.last_pixel  = col_end && line_end;

    case (depth_r)
      DEPTH_1:           s1_nxt.fmt = FMT_MONO;
      DEPTH_15, DEPTH_16: s1_nxt.fmt = FMT_555;
      DEPTH_24:          s1_nxt.fmt = FMT_RGB24;
      default:           s1_nxt.fmt = FMT_RGB32;
    endcase

    case (depth_r)
      DEPTH_1, DEPTH_15, DEPTH_16, DEPTH_24, DEPTH_32:
        s1_nxt.status = dims_ok ? ST_OK : ST_INVALID;
      DEPTH_4, DEPTH_8:
        s1_nxt.status = dims_ok ? ST_PALETTE : ST_INVALID;
      default:
        s1_nxt.status = ST_INVALID;
    endcase

    if (col_end) begin
      column_count_nxt = '0;
      line_count_nxt   = line_end ? '0 : line + DIM_W'(1);
    end else begin
      column_count_nxt = col + DIM_W'(1);
      line_count_nxt   = line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r        <= DEPTH_RESET;
      width_r        <= DIM_RESET;
      height_r       <= DIM_RESET;
      column_count_r <= '0;
      line_count_r   <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (cfg_acc && cfg_hit) begin
        case (cfg_ch.index)
          REG_DEPTH:  depth_r  <= cfg_ch.data[DEPTH_W-1:0];
          REG_WIDTH:  width_r  <= cfg_ch.data[DIM_W-1:0];
          REG_HEIGHT: height_r <= cfg_ch.data[DIM_W-1:0];
          default: ;
        endcase
        // restart the shape
        column_count_r <= '0;
        line_count_r   <= '0;
      end else if (in_acc) begin
        column_count_r <= column_count_nxt;
        line_count_r   <= line_count_nxt;
      end
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= s1_nxt;
  end

  // ---------------- colour stage ----------------
  always_comb begin
    logic [CH_W-1:0] chk;
    logic            white, black;
    chk       = s1_r.odd ? CH_ZERO : CH_FULL;
    blue_nxt  = CH_ZERO;
    green_nxt = CH_ZERO;
    red_nxt   = CH_ZERO;
    alpha_nxt = CH_ZERO;
    white     = 1'b0;
    black     = 1'b0;
    if (s1_r.status == ST_OK) begin
      if (s1_r.fmt == FMT_MONO) begin
        if (!s1_r.and_bit) begin
          blue_nxt  = s1_r.xor_pixel[0] ? CH_FULL : CH_ZERO;
          green_nxt = blue_nxt;
          red_nxt   = blue_nxt;
          alpha_nxt = CH_FULL;
        end else if (s1_r.xor_pixel[0]) begin
          blue_nxt  = chk;
          green_nxt = chk;
          red_nxt   = chk;
          alpha_nxt = CH_FULL;
        end
      end else begin
        case (s1_r.fmt)
          FMT_555: begin
            blue_nxt  = ext5(s1_r.xor_pixel[4:0]);
            green_nxt = ext5(s1_r.xor_pixel[9:5]);
            red_nxt   = ext5(s1_r.xor_pixel[14:10]);
            alpha_nxt = CH_FULL;
          end
          FMT_RGB24: begin
            blue_nxt  = s1_r.xor_pixel[7:0];
            green_nxt = s1_r.xor_pixel[15:8];
            red_nxt   = s1_r.xor_pixel[23:16];
            alpha_nxt = CH_FULL;
          end
          default: begin
            blue_nxt  = s1_r.xor_pixel[7:0];
            green_nxt = s1_r.xor_pixel[15:8];
            red_nxt   = s1_r.xor_pixel[23:16];
            alpha_nxt = s1_r.xor_pixel[31:24];
          end
        endcase
        white = (blue_nxt == CH_FULL) && (green_nxt == CH_FULL) &&
                (red_nxt == CH_FULL) && (alpha_nxt == CH_FULL);
        black = (blue_nxt == CH_ZERO) && (green_nxt == CH_ZERO) &&
                (red_nxt == CH_ZERO) && (alpha_nxt == CH_FULL);
        if (s1_r.and_bit) begin
          if (white) begin
            blue_nxt  = chk;
            green_nxt = chk;
            red_nxt   = chk;
            alpha_nxt = CH_FULL;
          end else if ((s1_r.fmt == FMT_RGB24) || black) begin
            blue_nxt  = CH_ZERO;
            green_nxt = CH_ZERO;
            red_nxt   = CH_ZERO;
            alpha_nxt = CH_ZERO;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      blue_r        <= blue_nxt;
      green_r       <= green_nxt;
      red_r         <= red_nxt;
      alpha_r       <= alpha_nxt;
      pixel_index_r <= s1_r.pixel_index;
      last_pixel_r  <= s1_r.last_pixel;
      status_r      <= s1_r.status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.blue        = blue_r;
  assign out_ch.green       = green_r;
  assign out_ch.red         = red_r;
  assign out_ch.alpha       = alpha_r;
  assign out_ch.pixel_index = pixel_index_r;
  assign out_ch.last_pixel  = last_pixel_r;
  assign out_ch.status      = status_r;

  // ---------------- assertions ----------------
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc && cfg_hit |=> column_count_r == '0 && line_count_r == '0)
    else $error("shape not restarted after register write");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    column_count_r < wd && line_count_r < hd)
    else $error("scan counter beyond shape bound");

  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |->
      blue_r == CH_ZERO && green_r == CH_ZERO && red_r == CH_ZERO && alpha_r == CH_ZERO)
    else $error("colour present on error status");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_r))
    else $error("index stage dropped a stalled pixel");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the cursor shape renderer: random handshakes, own pixel predictor.
module tb_top import pmbr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AT     = 160;
  localparam int HOLD_LEN    = 96;
  localparam int PRINT_CAP   = 200;

  typedef struct packed {
    logic             and_bit;
    logic [XOR_W-1:0] xor_pixel;
  } mask_px_t;

  typedef struct packed {
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  alpha;
    logic [IDX_W-1:0] pixel_index;
    logic             last_pixel;
    status_t          status;
  } bgra_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pmbr_cfg_if cfg_ch ();
  pmbr_in_if  in_ch ();
  pmbr_out_if out_ch ();

  pointer_mask_to_bgra_renderer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mask_px_t pending_px[$];
  bgra_px_t expected_px[$];
  bgra_px_t want;

  // shadow of the renderer's registers and scan counters
  logic [DEPTH_W-1:0] m_depth    = DEPTH_32;
  logic [DIM_W-1:0]   m_width    = DIM_RESET;
  logic [DIM_W-1:0]   m_height   = DIM_RESET;
  logic [DIM_W-1:0]   m_col      = '0;
  logic [DIM_W-1:0]   m_line     = '0;
  logic [IDX_W-1:0]   m_row_base = '0;

  int   errors     = 0;
  int   pixels_in  = 0;
  int   pixels_out = 0;
  int   settings   = 0;
  int   cycles     = 0;
  int   in_gap     = 0;
  int   out_gap    = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  logic idle_on    = 1'b1;
  logic in_fire    = 1'b0;

  function automatic logic [CH_W-1:0] widen5(input logic [4:0] v);
    return {v, 3'b000} | CH_W'(v >> 2);
  endfunction

  function automatic bgra_px_t render_pixel(input logic and_bit, input logic [XOR_W-1:0] xv);
    int unsigned     wd, hd, col, row, y;
    logic            dims_ok, depth_ok, white, black;
    logic [CH_W-1:0] chk;
    bgra_px_t        px;
    wd = (m_width == 0) ? 1 : (m_width > MAX_DIM) ? MAX_DIM : m_width;
    hd = (m_height == 0) ? 1 : (m_height > MAX_DIM) ? MAX_DIM : m_height;
    col = (m_col < wd) ? m_col : 0;
    row = (m_line < hd) ? m_line : 0;
    // stored bottom-up except at 1 bpp
    y = (m_depth == DEPTH_1) ? row : hd - 1 - row;
    if (col == 0) m_row_base = IDX_W'(y * wd);
    dims_ok = m_width >= 1 && m_width <= MAX_DIM && m_height >= 1 && m_height <= MAX_DIM;
    depth_ok = m_depth inside {DEPTH_1, DEPTH_4, DEPTH_8, DEPTH_15, DEPTH_16, DEPTH_24,
                               DEPTH_32};
    px = '0;
    if (!dims_ok || !depth_ok) px.status = ST_INVALID;
    else if (m_depth == DEPTH_4 || m_depth == DEPTH_8) px.status = ST_PALETTE;
    else px.status = ST_OK;
    if (px.status == ST_OK) begin
      chk = ((col + y) & 1) ? CH_ZERO : CH_FULL;
      if (m_depth == DEPTH_1) begin
        if (!and_bit) begin
          px.blue  = xv[0] ? CH_FULL : CH_ZERO;
          px.green = px.blue;
          px.red   = px.blue;
          px.alpha = CH_FULL;
        end else if (xv[0]) begin
          px.blue  = chk;
          px.green = chk;
          px.red   = chk;
          px.alpha = CH_FULL;
        end
      end else begin
        if (m_depth == DEPTH_32 || m_depth == DEPTH_24) begin
          px.blue  = xv[7:0];
          px.green = xv[15:8];
          px.red   = xv[23:16];
          px.alpha = (m_depth == DEPTH_32) ? xv[31:24] : CH_FULL;
        end else begin
          px.red   = widen5(xv[14:10]);
          px.green = widen5(xv[9:5]);
          px.blue  = widen5(xv[4:0]);
          px.alpha = CH_FULL;
        end
        if (and_bit) begin
          white = px.blue == CH_FULL && px.green == CH_FULL && px.red == CH_FULL &&
                  px.alpha == CH_FULL;
          black = px.blue == CH_ZERO && px.green == CH_ZERO && px.red == CH_ZERO &&
                  px.alpha == CH_FULL;
          if (white) begin
            px.blue  = chk;
            px.green = chk;
            px.red   = chk;
          end else if (m_depth == DEPTH_24 || black) begin
            px.blue  = CH_ZERO;
            px.green = CH_ZERO;
            px.red   = CH_ZERO;
            px.alpha = CH_ZERO;
          end
        end
      end
    end
    px.pixel_index = IDX_W'(m_row_base + col);
    px.last_pixel  = (col == wd - 1) && (row == hd - 1);
    if (col + 1 >= wd) begin
      m_col  = '0;
      m_line = (row + 1 >= hd) ? '0 : DIM_W'(row + 1);
    end else begin
      m_col  = DIM_W'(col + 1);
      m_line = DIM_W'(row);
    end
    return px;
  endfunction

  // bias towards opaque white and opaque black, where the AND bit matters most
  function automatic logic [XOR_W-1:0] pick_xor(input logic [DEPTH_W-1:0] depth);
    logic [XOR_W-1:0] v;
    int               kind;
    v = $urandom();
    kind = $urandom_range(0, 3);
    if (kind == 0) begin
      case (depth)
        DEPTH_32:           v = '1;
        DEPTH_24:           v[23:0] = '1;
        DEPTH_15, DEPTH_16: v[14:0] = '1;
        default: ;
      endcase
    end else if (kind == 1) begin
      case (depth)
        DEPTH_32:           v = {CH_FULL, 24'h0};
        DEPTH_24:           v[23:0] = '0;
        DEPTH_15, DEPTH_16: v[14:0] = '0;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic add_pixel(input logic and_bit, input logic [XOR_W-1:0] xv);
    mask_px_t m;
    m.and_bit = and_bit;
    m.xor_pixel = xv;
    pending_px.push_back(m);
  endtask

  task automatic drain();
    while (pending_px.size() != 0 || expected_px.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_DEPTH:  m_depth  = val[DEPTH_W-1:0];
      REG_WIDTH:  m_width  = val;
      REG_HEIGHT: m_height = val;
      default: ;
    endcase
    // any write restarts the shape
    m_col = '0;
    m_line = '0;
    m_row_base = '0;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_shape(input logic [DEPTH_W-1:0] depth,
                           input logic [CFG_DATA_W-1:0] width, height);
    drain();
    write_reg(REG_DEPTH, CFG_DATA_W'(depth));
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    settings++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t ns: pixel %0d %s expected 0x%0h got 0x%0h",
                 $time, pixels_out, fname, want_v, got_v);
    end
  endtask

  // input side: predict on every accepted beat
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      expected_px.push_back(render_pixel(in_ch.and_bit, in_ch.xor_pixel));
      void'(pending_px.pop_front());
      pixels_in++;
    end
  end

  always @(negedge clk) begin
    // hold an offered beat until it is taken
    if (rst_n && !(in_ch.valid && !in_fire)) begin
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_px.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= $urandom_range(0, 3);
      end else begin
        in_ch.valid     <= 1'b1;
        in_ch.and_bit   <= pending_px[0].and_bit;
        in_ch.xor_pixel <= pending_px[0].xor_pixel;
      end
    end
  end

  // long output stall once, so the pipeline backs up into the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && pixels_in >= HOLD_AT && pending_px.size() >= 8) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t ns: pixel beat with nothing expected, index 0x%0h",
                   $time, out_ch.pixel_index);
      end else begin
        want = expected_px.pop_front();
        check_field("blue", 32'(want.blue), 32'(out_ch.blue));
        check_field("green", 32'(want.green), 32'(out_ch.green));
        check_field("red", 32'(want.red), 32'(out_ch.red));
        check_field("alpha", 32'(want.alpha), 32'(out_ch.alpha));
        check_field("pixel_index", 32'(want.pixel_index), 32'(out_ch.pixel_index));
        check_field("last_pixel", 32'(want.last_pixel), 32'(out_ch.last_pixel));
        check_field("status", 32'(want.status), 32'(out_ch.status));
      end
      pixels_out++;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d pixels outstanding",
             expected_px.size() + pending_px.size());
    $display("pointer_mask_to_bgra_renderer_top: mismatch");
    $finish;
  end

  initial begin
    int                    phase, n, sel;
    logic [DEPTH_W-1:0]    dsel;
    logic [CFG_DATA_W-1:0] w, h;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_DEPTH;
    cfg_ch.data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.and_bit   = 1'b0;
    in_ch.xor_pixel = '0;
    out_ch.ready    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset shape, 32 bpp: white, black, colour and clear-alpha white under the AND bit
    add_pixel(1'b0, 32'h0000_0000);
    add_pixel(1'b0, 32'hFFFF_FFFF);
    add_pixel(1'b1, 32'hFFFF_FFFF);
    add_pixel(1'b1, 32'hFF00_0000);
    add_pixel(1'b1, 32'h1234_5678);
    add_pixel(1'b1, 32'h00FF_FFFF);
    // mono, top-down, wraps into a second shape
    set_shape(DEPTH_1, 9'd2, 9'd2);
    add_pixel(1'b0, 32'h0000_0000);
    add_pixel(1'b0, 32'h0000_0001);
    add_pixel(1'b1, 32'h0000_0000);
    add_pixel(1'b1, 32'h0000_0001);
    add_pixel(1'b0, 32'hFFFF_FFFE);
    set_shape(DEPTH_16, 9'd3, 9'd1);
    add_pixel(1'b0, 32'h0000_7FFF);
    add_pixel(1'b1, 32'h0000_7FFF);
    add_pixel(1'b1, 32'h0000_8000);
    add_pixel(1'b1, 32'hFFFF_7C1F);
    set_shape(DEPTH_24, 9'd1, 9'd3);
    add_pixel(1'b1, 32'h00FF_FFFF);
    add_pixel(1'b1, 32'h0012_3456);
    add_pixel(1'b0, 32'hAB12_3456);
    set_shape(DEPTH_4, 9'd2, 9'd1);
    add_pixel(1'b1, 32'hFFFF_FFFF);
    add_pixel(1'b0, 32'h1234_5678);
    set_shape(DEPTH_8, 9'd384, 9'd384);
    add_pixel(1'b0, 32'hFFFF_FFFF);
    // invalid depths, then sizes out of range
    set_shape(6'd0, 9'd1, 9'd1);
    add_pixel(1'b0, 32'hFFFF_FFFF);
    set_shape(6'd63, 9'd4, 9'd4);
    add_pixel(1'b0, 32'h8000_0001);
    set_shape(DEPTH_15, 9'd0, 9'd2);
    add_pixel(1'b1, 32'h0000_7FFF);
    set_shape(DEPTH_32, 9'd5, 9'd385);
    add_pixel(1'b0, 32'h7FFF_FFFF);
    set_shape(DEPTH_1, 9'd511, 9'd4);
    add_pixel(1'b0, 32'h0000_0001);

    for (phase = 0; phase < 14; phase++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1:    dsel = DEPTH_1;
        2:       dsel = DEPTH_15;
        3:       dsel = DEPTH_16;
        4, 5:    dsel = DEPTH_24;
        6, 7:    dsel = DEPTH_32;
        8:       dsel = $urandom_range(0, 1) ? DEPTH_4 : DEPTH_8;
        default: dsel = DEPTH_W'($urandom_range(0, 63));
      endcase
      w = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 511)) :
                                         CFG_DATA_W'($urandom_range(1, 6));
      h = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 511)) :
                                         CFG_DATA_W'($urandom_range(1, 6));
      // largest shape: bottom-up start lands near the top of the index range
      if (phase == 6) begin
        dsel = DEPTH_24;
        w = 9'd384;
        h = 9'd384;
      end
      set_shape(dsel, w, h);
      idle_on = (phase >= 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
      n = (phase == 6) ? 24 : $urandom_range(32, 48);
      repeat (n) add_pixel(1'($urandom_range(0, 1)), pick_xor(dsel));
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Rendered %0d pixels in %0d cycles over %0d shape settings at 1, 15/16, 24, 32 bpp,",
             pixels_out, cycles, settings);
    $display("plus palette and invalid settings, clamped sizes, restarts and a long output stall.");
    if (errors == 0) begin
      $display("pointer_mask_to_bgra_renderer_top: match");
    end else begin
      $display("pointer_mask_to_bgra_renderer_top: mismatch");
    end
    $finish;
  end

endmodule
